### hw/rtl/html_escape_stream_top_assert.svh
// Assertion macros for the HTML escape stream block.
// Included by html_escape_stream_top.sv; needs nothing else.
`ifndef HTML_ESCAPE_STREAM_TOP_ASSERT_SVH
`define HTML_ESCAPE_STREAM_TOP_ASSERT_SVH
`ifndef SYNTH
`define HES_ASSERT_IMPLIES(label, clock, resetn, cond, expr, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |-> (expr)) \
        else $error(msg);
`define HES_ASSERT_NEXT(label, clock, resetn, cond, expr, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (cond) |=> (expr)) \
        else $error(msg);
`else
`define HES_ASSERT_IMPLIES(label, clock, resetn, cond, expr, msg)
`define HES_ASSERT_NEXT(label, clock, resetn, cond, expr, msg)
`endif
`endif

### hw/rtl/hes_pkg.sv
// Package for the HTML escape stream block: item kinds, register map, entity table.
// Used by html_escape_stream_top.sv; depends on nothing.
package hes_pkg;

    localparam int unsigned POSITION_BITS_DEFAULT = 16;

    localparam logic [15:0] BUFFER_LENGTH_RESET = 16'd256;
    localparam logic [1:0]  NEWLINE_MODE_RESET  = 2'd0;

    // Register index, taken from paddr[2].
    localparam logic REG_BUFFER_LENGTH = 1'b0;
    localparam logic REG_NEWLINE_MODE  = 1'b1;

    localparam logic [1:0] NL_DROP = 2'd0;
    localparam logic [1:0] NL_PASS = 2'd1;

    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_QUOTE = 8'h22;
    localparam logic [7:0] CHR_AMP   = 8'h26;
    localparam logic [7:0] CHR_LT    = 8'h3C;
    localparam logic [7:0] CHR_GT    = 8'h3E;

    typedef enum logic [2:0] {
        ITEM_CHAR,
        ITEM_AMP,
        ITEM_QUOT,
        ITEM_LT,
        ITEM_GT,
        ITEM_BR
    } item_kind_t;

    // Number of bytes that an item emits.
    function automatic logic [2:0] item_len(input item_kind_t kind);
        logic [2:0] len;
        case (kind)
            ITEM_AMP:  len = 3'd5;
            ITEM_QUOT: len = 3'd6;
            ITEM_LT:   len = 3'd4;
            ITEM_GT:   len = 3'd4;
            ITEM_BR:   len = 3'd4;
            default:   len = 3'd1;
        endcase
        return len;
    endfunction

    // Byte idx of an item; a plain character item emits its own byte.
    function automatic logic [7:0] item_byte(input item_kind_t kind, input logic [2:0] idx,
                                             input logic [7:0] ch);
        logic [7:0] b;
        b = 8'h00;
        case (kind)
            ITEM_AMP:
                case (idx)
                    3'd0:    b = "&";
                    3'd1:    b = "a";
                    3'd2:    b = "m";
                    3'd3:    b = "p";
                    default: b = ";";
                endcase
            ITEM_QUOT:
                case (idx)
                    3'd0:    b = "&";
                    3'd1:    b = "q";
                    3'd2:    b = "u";
                    3'd3:    b = "o";
                    3'd4:    b = "t";
                    default: b = ";";
                endcase
            ITEM_LT:
                case (idx)
                    3'd0:    b = "&";
                    3'd1:    b = "l";
                    3'd2:    b = "t";
                    default: b = ";";
                endcase
            ITEM_GT:
                case (idx)
                    3'd0:    b = "&";
                    3'd1:    b = "g";
                    3'd2:    b = "t";
                    default: b = ";";
                endcase
            ITEM_BR:
                case (idx)
                    3'd0:    b = "<";
                    3'd1:    b = "b";
                    3'd2:    b = "r";
                    default: b = ">";
                endcase
            default: b = ch;
        endcase
        return b;
    endfunction

endpackage

### hw/rtl/html_escape_stream_top.sv
// HTML escape stream, top level: stream in, stream out, APB configuration.
// Depends on hes_pkg.sv and html_escape_stream_top_assert.svh.
//
// Usage
// The slave stream (s_tvalid, s_tready, s_tdata) carries one source character per
// word. The master stream (m_tvalid, m_tready, m_tdata, m_tlast) carries the escaped
// text; m_tlast marks the final output word caused by one input word. A zero input
// byte ends the string: it always produces one zero word and clears the position.
// The characters & " < > expand to four to six words; CR and LF follow newline_mode.
// Words that would not fit in buffer_length (terminator included) are dropped.
// The first output word of an input appears in the cycle after acceptance.
// Throughput: one input word per cycle for plain characters while m_tready stays
// high. An entity holds s_tready low while its bytes (up to six) drain from the
// output register, stepped by the expansion index counter.
// A dropped input is still accepted and produces no word.
// When the receiver stalls, the current output word holds, and s_tready drops once
// the output register holds a word that is not being taken.
// Reset (rst_n low, asynchronous) empties the output register, clears the position
// and loads buffer_length 256 and newline_mode 0.
// APB: buffer_length at 0x0, newline_mode at 0x4; pready is always high.
`include "html_escape_stream_top_assert.svh"

module html_escape_stream_top #(
    parameter int unsigned POSITION_BITS = hes_pkg::POSITION_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // run_last
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hes_pkg::*;

    // Compare width: holds position plus an item length and the 16-bit buffer length.
    localparam int unsigned CW = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 2;

    logic [15:0]              buffer_length_reg;
    logic [1:0]               newline_mode_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;

    logic       out_valid_reg, out_valid_next;
    item_kind_t kind_reg, kind_next;
    logic [2:0] idx_reg, idx_next;
    logic [7:0] char_reg, char_next;

    logic       cfg_write;
    logic       s_accept;
    logic       m_accept;
    logic       last_word;
    logic       busy;

    item_kind_t sel_kind;
    logic       sel_drop;
    logic [2:0] sel_len;
    logic [CW-1:0] sum;
    logic       fits;
    logic       emit;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_length_reg <= BUFFER_LENGTH_RESET;
            newline_mode_reg  <= NEWLINE_MODE_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_BUFFER_LENGTH: buffer_length_reg <= pwdata[15:0];
                REG_NEWLINE_MODE:  newline_mode_reg  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_BUFFER_LENGTH: prdata = {16'd0, buffer_length_reg};
            REG_NEWLINE_MODE:  prdata = {30'd0, newline_mode_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // Handshake. The block takes a new word unless the output register holds a
    // word that stays there this cycle, or an entity has bytes left after it.
    assign last_word = (idx_reg == item_len(kind_reg) - 3'd1);
    assign m_accept  = out_valid_reg && m_tready;
    assign busy      = out_valid_reg && !(m_tready && last_word);
    assign s_tready  = !busy;
    assign s_accept  = s_tvalid && s_tready;

    // Classify the incoming character.
    always_comb
    begin
        sel_kind = ITEM_CHAR;
        sel_drop = 1'b0;
        case (s_tdata)
            CHR_AMP:   sel_kind = ITEM_AMP;
            CHR_QUOTE: sel_kind = ITEM_QUOT;
            CHR_LT:    sel_kind = ITEM_LT;
            CHR_GT:    sel_kind = ITEM_GT;
            CHR_CR:
            begin
                if (newline_mode_reg == NL_DROP)
                    sel_drop = 1'b1;
                else if (newline_mode_reg != NL_PASS)
                    sel_kind = ITEM_BR;
            end
            CHR_LF:    sel_drop = (newline_mode_reg == NL_DROP);
            default:   sel_kind = ITEM_CHAR;
        endcase
    end

    // Budget check: position plus item length must stay below both the buffer
    // length and 2^POSITION_BITS. Exact compare at a width that cannot wrap.
    assign sel_len = item_len(sel_kind);
    assign sum     = CW'(pos_reg) + CW'(sel_len);
    assign fits    = (sum < CW'(buffer_length_reg)) && (sum[CW-1:POSITION_BITS] == '0);
    assign emit    = (s_tdata == CHR_NUL) || (!sel_drop && fits);

    always_comb
    begin
        pos_next = pos_reg;
        if (s_accept)
        begin
            if (s_tdata == CHR_NUL)
                pos_next = '0;
            else if (emit)
                pos_next = sum[POSITION_BITS-1:0];
        end
    end

    // Output register and expansion index.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        char_next      = char_reg;
        if (m_accept)
        begin
            if (last_word)
                out_valid_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
        if (s_accept && emit)
        begin
            out_valid_next = 1'b1;
            kind_next      = (s_tdata == CHR_NUL) ? ITEM_CHAR : sel_kind;
            idx_next       = 3'd0;
            char_next      = s_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            kind_reg      <= ITEM_CHAR;
            idx_reg       <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            kind_reg      <= kind_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = item_byte(kind_reg, idx_reg, char_reg);
    assign m_tlast  = last_word;

    // Checks.
    `HES_ASSERT_IMPLIES(a_idx_in_range, clk, rst_n, out_valid_reg,
        idx_reg < item_len(kind_reg), "expansion index past item length")
    `HES_ASSERT_NEXT(a_term_clears_pos, clk, rst_n, s_accept && (s_tdata == CHR_NUL),
        pos_reg == '0, "terminator did not clear position")
    `HES_ASSERT_NEXT(a_pos_only_on_accept, clk, rst_n, !s_accept,
        $stable(pos_reg), "position changed without an accepted word")
    `HES_ASSERT_IMPLIES(a_ready_after_last, clk, rst_n, m_tvalid && m_tready && m_tlast,
        s_tready, "input not ready while last output word is taken")

endmodule
